FILE: src/wnpg_pkg.sv
package wnpg_pkg;

    // Colour table geometry.
    localparam int TABLE_LEVELS = 256;
    localparam int TABLE_BYTES  = TABLE_LEVELS * 3;
    localparam int TBL_AW       = $clog2(TABLE_BYTES);
    localparam int ENTRY_W      = (TABLE_LEVELS > 2) ? $clog2(TABLE_LEVELS) : 1;

    // Generator constants: s' = (s * 0x5DEECE66D + 0xB) mod 2^48.
    localparam logic [31:0] LCG_MUL_LO = 32'hDEEC_E66D;
    localparam logic [2:0]  LCG_MUL_HI = 3'h5;
    localparam logic [47:0] LCG_ADD    = 48'hB;

    // Operation codes of an input transaction.
    localparam logic [1:0] OP_WRITE    = 2'd0;
    localparam logic [1:0] OP_GENERATE = 2'd1;
    localparam logic [1:0] OP_RELOAD   = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SEED        = 3'd0;
    localparam logic [2:0] CFG_PER_CHANNEL = 3'd1;
    localparam logic [2:0] CFG_DRAW_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_THRESHOLD   = 3'd3;
    localparam logic [2:0] CFG_BACKGROUND  = 3'd4;

    // Draw width codes; any other code selects the 8-bit draw.
    localparam logic [1:0] DW_1BIT = 2'd0;
    localparam logic [1:0] DW_3BIT = 2'd1;
    localparam logic [1:0] DW_8BIT = 2'd2;

    // Control of the shared generator step unit.
    typedef struct packed {
        logic load_seed;
        logic mul_lo;
        logic mul_hi;
    } lcg_ctrl_t;

    // Top bits of the generator state that form one draw.
    function automatic logic [7:0] draw_bits(input logic [47:0] s, input logic [1:0] w);
        logic [7:0] d;
        case (w)
            DW_1BIT: d = {7'b0, s[47]};
            DW_3BIT: d = {5'b0, s[47:45]};
            default: d = s[47:40];
        endcase
        return d;
    endfunction

endpackage

FILE: src/wnpg_lcg.sv
module wnpg_lcg
    import wnpg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lcg_ctrl_t   ctrl,
    input  logic [47:0] seed,
    output logic [47:0] state
);

    logic [47:0] state_reg;
    logic [47:0] state_next;
    logic [47:0] prod_reg;
    logic [63:0] lo_prod;
    logic [31:0] cross_a;
    logic [18:0] cross_b;
    logic [15:0] cross_sum;

    // First phase: low 32 bits of the state times the low 32 bits of the multiplier.
    assign lo_prod = 64'(state_reg[31:0]) * 64'(LCG_MUL_LO);

    // Second phase: the cross terms only matter in their low 16 bits.
    assign cross_a   = 32'(state_reg[47:32]) * 32'(LCG_MUL_LO[15:0]);
    assign cross_b   = 19'(state_reg[15:0]) * 19'(LCG_MUL_HI);
    assign cross_sum = cross_a[15:0] + cross_b[15:0];

    always_comb
    begin
        state_next = state_reg;
        if (ctrl.load_seed)
        begin
            state_next = seed;
        end
        else if (ctrl.mul_hi)
        begin
            state_next = prod_reg + {cross_sum, 32'b0} + LCG_ADD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // The partial product needs no reset.
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_lo)
        begin
            prod_reg <= lo_prod[47:0];
        end
    end

    assign state = state_reg;

endmodule

FILE: src/wnpg_table.sv
module wnpg_table
    import wnpg_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [TBL_AW-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [TBL_AW-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] table_mem [TABLE_BYTES];
    logic [7:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/white_noise_pixel_generator_core.sv
// Table write and reload transactions leave the block ready at once. A generate
// transaction steps the generator through the MUL_A and MUL_B states of the split
// multiplier, and reads each channel byte of a filled pixel through the registered
// colour table read in the ADDR and DATA states.
// Reset clears the control, the configuration and the generator state; the colour
// table is not cleared and holds undefined bytes until written.
module white_noise_pixel_generator_core
    import wnpg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [9:0]  table_address,
    input  logic [7:0]  table_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic        filled
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL_A = 7'b0000010,
        S_MUL_B = 7'b0000100,
        S_FILL  = 7'b0001000,
        S_ADDR  = 7'b0010000,
        S_DATA  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [47:0] seed_reg;
    logic        per_channel_reg;
    logic [1:0]  draw_width_reg;
    logic [16:0] threshold_reg;
    logic [23:0] background_reg;

    logic        fill_phase_reg, fill_phase_next;
    logic [1:0]  ch_reg, ch_next;
    logic [ENTRY_W-1:0] entry_reg, entry_next;
    logic [7:0]  pix_r_reg, pix_g_reg, pix_b_reg;
    logic        pix_filled_reg;
    logic        out_valid_reg;
    logic [7:0]  red_reg, green_reg, blue_reg;
    logic        filled_reg;

    logic        in_accept;
    logic        out_free;
    lcg_ctrl_t   lcg_ctrl;
    logic [47:0] gen_state;
    logic [7:0]  raw_draw;
    logic [ENTRY_W-1:0] drawn_entry;
    logic [TBL_AW-1:0]  entry_ext;
    logic [TBL_AW-1:0]  rd_addr;
    logic        tbl_wr_en;
    logic        tbl_rd_en;
    logic [7:0]  rd_data;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg        <= '0;
            per_channel_reg <= 1'b0;
            draw_width_reg  <= DW_8BIT;
            threshold_reg   <= 17'd65536;
            background_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SEED:        seed_reg        <= cfg_data;
                CFG_PER_CHANNEL: per_channel_reg <= cfg_data[0];
                CFG_DRAW_WIDTH:  draw_width_reg  <= cfg_data[1:0];
                CFG_THRESHOLD:   threshold_reg   <= cfg_data[16:0];
                CFG_BACKGROUND:  background_reg  <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // Draw from the current generator state, saturated to the table depth.
    assign raw_draw = draw_bits(gen_state, draw_width_reg);

    always_comb
    begin
        if (raw_draw > 8'(TABLE_LEVELS - 1))
        begin
            drawn_entry = ENTRY_W'(TABLE_LEVELS - 1);
        end
        else
        begin
            drawn_entry = ENTRY_W'(raw_draw);
        end
    end

    // A new draw for the first channel, or for every channel in per-channel mode.
    assign entry_next = ((ch_reg == 2'd0) || per_channel_reg) ? drawn_entry : entry_reg;
    assign entry_ext  = TBL_AW'(entry_next);
    assign rd_addr    = (entry_ext << 1) + entry_ext + TBL_AW'(ch_reg);
    assign tbl_rd_en  = (state_reg == S_ADDR);

    assign tbl_wr_en = in_accept && (operation == OP_WRITE)
                       && (table_address < 10'(TABLE_BYTES));

    // Generator step unit control.
    always_comb
    begin
        lcg_ctrl.load_seed = in_accept && (operation == OP_RELOAD);
        lcg_ctrl.mul_lo    = (state_reg == S_MUL_A);
        lcg_ctrl.mul_hi    = (state_reg == S_MUL_B);
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        fill_phase_next = fill_phase_reg;
        ch_next         = ch_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (operation == OP_GENERATE))
                begin
                    state_next      = S_MUL_A;
                    fill_phase_next = !threshold_reg[16];
                    ch_next         = 2'd0;
                end
            end
            S_MUL_A:
            begin
                state_next = S_MUL_B;
            end
            S_MUL_B:
            begin
                state_next = fill_phase_reg ? S_FILL : S_ADDR;
            end
            S_FILL:
            begin
                fill_phase_next = 1'b0;
                if ({1'b0, gen_state[47:32]} < threshold_reg)
                begin
                    state_next = S_MUL_A;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_ADDR:
            begin
                state_next = S_DATA;
            end
            S_DATA:
            begin
                if (ch_reg == 2'd2)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    ch_next    = ch_reg + 2'd1;
                    state_next = per_channel_reg ? S_MUL_A : S_ADDR;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_phase_reg <= 1'b0;
            ch_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_phase_reg <= fill_phase_next;
            ch_reg         <= ch_next;
            if ((state_reg == S_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Pixel assembly and the output register.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_ADDR)
        begin
            entry_reg <= entry_next;
        end
        if ((state_reg == S_FILL) && ({1'b0, gen_state[47:32]} >= threshold_reg))
        begin
            pix_r_reg      <= background_reg[7:0];
            pix_g_reg      <= background_reg[15:8];
            pix_b_reg      <= background_reg[23:16];
            pix_filled_reg <= 1'b0;
        end
        if (state_reg == S_DATA)
        begin
            pix_filled_reg <= 1'b1;
            case (ch_reg)
                2'd0:    pix_r_reg <= rd_data;
                2'd1:    pix_g_reg <= rd_data;
                default: pix_b_reg <= rd_data;
            endcase
        end
        if ((state_reg == S_OUT) && out_free)
        begin
            red_reg    <= pix_r_reg;
            green_reg  <= pix_g_reg;
            blue_reg   <= pix_b_reg;
            filled_reg <= pix_filled_reg;
        end
    end

    wnpg_lcg u_lcg (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (lcg_ctrl),
        .seed  (seed_reg),
        .state (gen_state)
    );

    wnpg_table u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (table_address[TBL_AW-1:0]),
        .wr_data (table_value),
        .rd_en   (tbl_rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign filled    = filled_reg;

endmodule

FILE: src/wnpg_checker.sv
module wnpg_checker
    import wnpg_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_write,
    input logic [2:0]  cfg_index,
    input logic [47:0] cfg_data,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  operation,
    input logic [9:0]  table_address,
    input logic [7:0]  table_value,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  red,
    input logic [7:0]  green,
    input logic [7:0]  blue,
    input logic        filled
);

    // The block holds off new transactions while a pixel is being generated.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (operation == OP_GENERATE)) |=> in_stall)
    else $error("generate transaction did not block the input");

    // A table write or reload never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (operation != OP_GENERATE) && !out_valid) |=> !out_valid)
    else $error("result appeared without a generate transaction");

    // A result never appears in the cycle after its generate transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (operation == OP_GENERATE) && !out_valid)
        |=> !out_valid)
    else $error("result appeared too early");

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(red) && $stable(green)
                                      && $stable(blue) && $stable(filled)))
    else $error("stalled result changed");

endmodule

bind white_noise_pixel_generator_core wnpg_checker u_checker (.*);
